### sv/kfs_pkg.sv
// shared types and constants of the scalar kalman smoother
package kfs_pkg;

  // channel count and field widths
  localparam int CHANNELS  = 4;
  localparam int CH_W      = 2;
  localparam int SAMPLE_W  = 8;
  localparam int FRAC_W    = 16;
  localparam int VAR_W     = 24;
  localparam int EST_W     = 25;
  localparam int K_W       = 16;
  localparam int QUO_W     = K_W + 1;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int PROD_W    = EST_W + QUO_W;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;

  // reset values
  localparam logic [EST_W-1:0] EST_RESET = 25'd65536;
  localparam logic [VAR_W-1:0] VAR_RESET = 24'd1966080;
  localparam logic [CFG_W-1:0] Q_RESET   = 24'd806;
  localparam logic [CFG_W-1:0] R_RESET   = 24'd1031641;

  // saturation limits and unity gain
  localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};
  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};
  localparam logic [K_W-1:0]   K_MAX   = {K_W{1'b1}};
  localparam logic [QUO_W-1:0] ONE_Q16 = {1'b1, {K_W{1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

  // one channel's stored state
  typedef struct packed {
    logic [EST_W-1:0] estimate;
    logic [VAR_W-1:0] variance;
  } kfs_state_t;

  // state memory port control
  typedef struct packed {
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    logic            wr_en;
    logic [CH_W-1:0] wr_addr;
  } kfs_mem_ctl_t;

endpackage

### sv/kfs_state_mem.sv
// per-channel state memory with registered read and reset-value valid bits
module kfs_state_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kfs_pkg::kfs_mem_ctl_t ctl,
  input  kfs_pkg::kfs_state_t  wr_data,
  output kfs_pkg::kfs_state_t  rd_data
);

  kfs_pkg::kfs_state_t                 mem [kfs_pkg::CHANNELS];
  logic [kfs_pkg::CHANNELS-1:0]        valid_r;
  kfs_pkg::kfs_state_t                 rd_raw_r;
  logic                                rd_valid_r;
  kfs_pkg::kfs_state_t                 reset_entry;

  // storage array, written and read in clocked blocks
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_raw_r <= mem[ctl.rd_addr];
    end
  end

  // valid bits: an entry never written reads as the reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[ctl.rd_addr];
      end
    end
  end

  assign reset_entry.estimate = kfs_pkg::EST_RESET;
  assign reset_entry.variance = kfs_pkg::VAR_RESET;
  assign rd_data = rd_valid_r ? rd_raw_r : reset_entry;

endmodule

### sv/kfs_div.sv
// radix-2 restoring divider for the gain: floor(dividend * 2^16 / divisor)
module kfs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kfs_pkg::VAR_W-1:0]   dividend,
  input  logic [kfs_pkg::EST_W-1:0]   divisor,
  output logic                        done,
  output logic [kfs_pkg::QUO_W-1:0]   quotient
);

  logic                             busy_r;
  logic                             done_r;
  logic [kfs_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [kfs_pkg::EST_W-1:0]        rem_r;
  logic [kfs_pkg::EST_W-1:0]        den_r;
  logic [kfs_pkg::QUO_W-1:0]        quo_r;
  logic [kfs_pkg::EST_W:0]          trial;
  logic [kfs_pkg::EST_W:0]          diff;
  logic                             qbit;

  // first step compares the dividend itself, later steps shift in a zero
  always_comb begin
    if (cnt_r == '0) begin
      trial = {1'b0, rem_r};
    end else begin
      trial = {rem_r, 1'b0};
    end
    diff = trial - {1'b0, den_r};
    qbit = (trial >= {1'b0, den_r});
  end

  // control: count quotient bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == kfs_pkg::DIV_CNT_W'(kfs_pkg::QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
          cnt_r  <= cnt_r + 1'b1;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[kfs_pkg::EST_W-1:0] : trial[kfs_pkg::EST_W-1:0];
      quo_r <= {quo_r[kfs_pkg::QUO_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/scalar_kalman_smoother.sv
// top level of the scalar kalman smoother: sequencer, datapath and config registers
//
//   port group   direction  handshake          payload
//   in_*         input      in_valid/in_stall    channel, sample, nudge
//   out_*        output     out_valid/out_stall  channel_out, filtered
//   cfg_*        input      cfg_we               cfg_index, cfg_data
//
// one beat in, one beat out; an item goes from acceptance to its result being offered
// through read, prepare, 17 gain divider steps and the divider done step, two shared
// multiplier steps and write-back; the next beat is not taken before the previous item
// has left write-back. in_stall is high while an item is in work.
// the result register lets the next beat enter while a result waits; a result
// stalled at the output holds the sequencer in write-back. rst_n is synchronous;
// after reset every channel reads as estimate 1.0, variance 30.0.
module scalar_kalman_smoother (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kfs_pkg::CH_W-1:0]        in_channel,
  input  logic [kfs_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic [kfs_pkg::SAMPLE_W-1:0]    in_nudge,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kfs_pkg::CH_W-1:0]        out_channel_out,
  output logic [kfs_pkg::SAMPLE_W-1:0]    out_filtered,
  input  logic                            cfg_we,
  input  logic [kfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kfs_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_MULA = 3'd4;
  localparam logic [2:0] ST_MULB = 3'd5;
  localparam logic [2:0] ST_WB   = 3'd6;

  logic [2:0]                         state_r;
  logic [2:0]                         state_nxt;

  logic [kfs_pkg::CFG_W-1:0]          q_r;
  logic [kfs_pkg::CFG_W-1:0]          r_r;

  logic [kfs_pkg::CH_W-1:0]           ch_r;
  logic                               ch_ok_r;
  logic [kfs_pkg::SAMPLE_W-1:0]       sample_r;
  logic [kfs_pkg::SAMPLE_W-1:0]       nudge_r;
  logic [kfs_pkg::EST_W-1:0]          xp_r;
  logic [kfs_pkg::VAR_W-1:0]          pp_r;
  logic                               den_zero_r;
  logic [kfs_pkg::EST_W-1:0]          diff_r;
  logic                               up_r;
  logic [kfs_pkg::K_W-1:0]            k_r;
  logic [kfs_pkg::PROD_W-1:0]         prod_r;
  logic [kfs_pkg::EST_W-1:0]          xn_r;

  logic                               out_valid_r;
  logic [kfs_pkg::CH_W-1:0]           out_ch_r;
  logic [kfs_pkg::SAMPLE_W-1:0]       out_filt_r;

  logic                               accept;
  logic                               out_load;
  kfs_pkg::kfs_mem_ctl_t              mem_ctl;
  kfs_pkg::kfs_state_t                mem_rd;
  kfs_pkg::kfs_state_t                mem_wr;
  logic                               div_start;
  logic                               div_done;
  logic [kfs_pkg::QUO_W-1:0]          div_quo;

  logic [kfs_pkg::EST_W:0]            xp_sum;
  logic [kfs_pkg::VAR_W:0]            pp_sum;
  logic [kfs_pkg::EST_W:0]            den_sum;
  logic [kfs_pkg::EST_W-1:0]          z_ext;
  logic [kfs_pkg::EST_W-1:0]          mul_a;
  logic [kfs_pkg::QUO_W-1:0]          mul_b;
  logic [kfs_pkg::EST_W-1:0]          corr;
  logic [kfs_pkg::EST_W:0]            xn_up;
  logic [kfs_pkg::EST_W-1:0]          xn_val;
  logic [kfs_pkg::EST_W-kfs_pkg::FRAC_W-1:0] whole;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_WB) && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= kfs_pkg::Q_RESET;
      r_r <= kfs_pkg::R_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kfs_pkg::CFG_PROCESS_NOISE:     q_r <= cfg_data;
        kfs_pkg::CFG_MEASUREMENT_NOISE: r_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_MULA;
      ST_MULA: state_nxt = ST_MULB;
      ST_MULB: state_nxt = ST_WB;
      ST_WB:   if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // state memory: read at acceptance, write back once the result is handed over
  assign mem_ctl.rd_en   = accept;
  assign mem_ctl.rd_addr = in_channel;
  assign mem_ctl.wr_en   = out_load && ch_ok_r;
  assign mem_ctl.wr_addr = ch_r;
  assign mem_wr.estimate = xn_r;
  assign mem_wr.variance = prod_r[kfs_pkg::VAR_W+kfs_pkg::FRAC_W-1:kfs_pkg::FRAC_W];

  kfs_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .wr_data (mem_wr),
    .rd_data (mem_rd)
  );

  // gain divider, divisor taken straight from the prior variance plus noise
  assign div_start = (state_r == ST_PREP);

  kfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pp_r),
    .divisor  (den_sum[kfs_pkg::EST_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // prediction sums (saturated when registered), gain denominator and scaled sample
  always_comb begin
    xp_sum  = {1'b0, mem_rd.estimate}
            + {2'b00, nudge_r, {kfs_pkg::FRAC_W{1'b0}}};
    pp_sum  = {1'b0, mem_rd.variance} + {1'b0, q_r};
    den_sum = {2'b00, pp_r} + {2'b00, r_r};
    z_ext   = {1'b0, sample_r, {kfs_pkg::FRAC_W{1'b0}}};
  end

  // shared multiplier operands: correction first, then variance update
  always_comb begin
    if (state_r == ST_MULA) begin
      mul_a = diff_r;
      mul_b = {1'b0, k_r};
    end else begin
      mul_a = {1'b0, pp_r};
      mul_b = kfs_pkg::ONE_Q16 - {1'b0, k_r};
    end
  end

  // estimate update from the correction product
  always_comb begin
    corr  = prod_r[kfs_pkg::EST_W+kfs_pkg::FRAC_W-1:kfs_pkg::FRAC_W];
    xn_up = {1'b0, xp_r} + {1'b0, corr};
    if (up_r) begin
      xn_val = xn_up[kfs_pkg::EST_W] ? kfs_pkg::EST_MAX : xn_up[kfs_pkg::EST_W-1:0];
    end else begin
      xn_val = xp_r - corr;
    end
    whole = xn_r[kfs_pkg::EST_W-1:kfs_pkg::FRAC_W];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r     <= in_channel;
      ch_ok_r  <= ({1'b0, in_channel} < (kfs_pkg::CH_W + 1)'(kfs_pkg::CHANNELS));
      sample_r <= in_sample;
      nudge_r  <= in_nudge;
    end
    if (state_r == ST_READ) begin
      xp_r <= xp_sum[kfs_pkg::EST_W] ? kfs_pkg::EST_MAX : xp_sum[kfs_pkg::EST_W-1:0];
      pp_r <= pp_sum[kfs_pkg::VAR_W] ? kfs_pkg::VAR_MAX : pp_sum[kfs_pkg::VAR_W-1:0];
    end
    if (state_r == ST_PREP) begin
      den_zero_r <= (den_sum == '0);
    end
    if (state_r == ST_DIV) begin
      up_r   <= (z_ext >= xp_r);
      diff_r <= (z_ext >= xp_r) ? (z_ext - xp_r) : (xp_r - z_ext);
      if (den_zero_r) begin
        k_r <= '0;
      end else if (div_quo[kfs_pkg::K_W]) begin
        k_r <= kfs_pkg::K_MAX;
      end else begin
        k_r <= div_quo[kfs_pkg::K_W-1:0];
      end
    end
    if (state_r == ST_MULA || state_r == ST_MULB) begin
      prod_r <= kfs_pkg::PROD_W'(mul_a) * kfs_pkg::PROD_W'(mul_b);
    end
    if (state_r == ST_MULB) begin
      xn_r <= xn_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r <= ch_r;
      if (!ch_ok_r) begin
        out_filt_r <= '0;
      end else if (whole[kfs_pkg::EST_W-kfs_pkg::FRAC_W-1]) begin
        out_filt_r <= {kfs_pkg::SAMPLE_W{1'b1}};
      end else begin
        out_filt_r <= whole[kfs_pkg::SAMPLE_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_filtered    = out_filt_r;

endmodule

### tb/sv/scalar_kalman_smoother_test.sv
// self-checking testbench of the scalar kalman smoother with a built-in per-channel predictor
module scalar_kalman_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kfs_pkg::*;

  // one sample beat waiting to be sent
  typedef struct {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] nudge;
  } sample_beat_t;

  // one filtered value still to come back
  typedef struct {
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] value;
  } filtered_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CH_W-1:0]      in_channel = '0;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic [SAMPLE_W-1:0]  in_nudge = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CH_W-1:0]      out_channel_out;
  logic [SAMPLE_W-1:0]  out_filtered;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor copy of the filter state and noise settings
  logic [EST_W-1:0] est_mem [CHANNELS];
  logic [VAR_W-1:0] var_mem [CHANNELS];
  logic [CFG_W-1:0] q_noise;
  logic [CFG_W-1:0] r_noise;

  sample_beat_t   beats_to_send [$];
  filtered_beat_t filtered_due [$];
  sample_beat_t   next_beat;
  filtered_beat_t due_now;
  filtered_beat_t seen_due;
  int             mismatches = 0;
  int             gap_left = 0;
  int             stall_left = 0;
  bit             gaps_on = 1'b1;
  bit             stall_on = 1'b1;

  scalar_kalman_smoother DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel      (in_channel),
    .in_sample       (in_sample),
    .in_nudge        (in_nudge),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_channel_out (out_channel_out),
    .out_filtered    (out_filtered),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // one kalman step on the predictor state, returns the saturated integer estimate
  function automatic logic [SAMPLE_W-1:0] kalman_update(input logic [CH_W-1:0] ch,
                                                         input logic [SAMPLE_W-1:0] z_in,
                                                         input logic [SAMPLE_W-1:0] nudge);
    logic [63:0] z;
    logic [63:0] x_prior;
    logic [63:0] p_prior;
    logic [63:0] denom;
    logic [63:0] gain;
    logic [63:0] delta;
    logic [63:0] corr;
    logic [63:0] x_post;
    logic [63:0] p_post;
    z = 64'(z_in) << FRAC_W;
    // prediction, both terms saturating
    x_prior = 64'(est_mem[ch]) + (64'(nudge) << FRAC_W);
    if (x_prior > 64'(EST_MAX)) x_prior = 64'(EST_MAX);
    p_prior = 64'(var_mem[ch]) + 64'(q_noise);
    if (p_prior > 64'(VAR_MAX)) p_prior = 64'(VAR_MAX);
    // gain, zero when the denominator is zero
    denom = p_prior + 64'(r_noise);
    if (denom == 64'd0) begin
      gain = 64'd0;
    end else begin
      gain = (p_prior << FRAC_W) / denom;
      if (gain > 64'(K_MAX)) gain = 64'(K_MAX);
    end
    // correction truncates toward zero on the magnitude
    if (z >= x_prior) begin
      delta = z - x_prior;
      corr = (delta * gain) >> FRAC_W;
      x_post = x_prior + corr;
    end else begin
      delta = x_prior - z;
      corr = (delta * gain) >> FRAC_W;
      x_post = x_prior - corr;
    end
    if (x_post > 64'(EST_MAX)) x_post = 64'(EST_MAX);
    p_post = (((64'd1 << FRAC_W) - gain) * p_prior) >> FRAC_W;
    est_mem[ch] = x_post[EST_W-1:0];
    var_mem[ch] = p_post[VAR_W-1:0];
    if ((x_post >> FRAC_W) > 64'd255) return 8'd255;
    return x_post[FRAC_W +: SAMPLE_W];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_beat(input int ch, input int sample, input int nudge);
    sample_beat_t b;
    b.ch = CH_W'(ch);
    b.sample = SAMPLE_W'(sample);
    b.nudge = SAMPLE_W'(nudge);
    beats_to_send.push_back(b);
  endtask

  // random beat, nudge mostly zero and samples leaning to the extremes now and then
  task automatic queue_random_beats(input int count);
    int s;
    int n;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: s = 0;
        1: s = 255;
        default: s = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 11))
        0, 1: n = $urandom_range(1, 255);
        2: n = 255;
        default: n = 0;
      endcase
      queue_beat($urandom_range(0, CHANNELS - 1), s, n);
    end
  endtask

  // register write, only issued while the block is idle
  task automatic set_noise(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_PROCESS_NOISE) q_noise = value;
    else if (idx == CFG_MEASUREMENT_NOISE) r_noise = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // hold until every beat is sent and every filtered value is back
  task automatic wait_quiet();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || filtered_due.size() != 0);
  endtask

  // sender: predicts at each accepted beat, then presents the next one or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_now.ch = in_channel;
        due_now.value = kalman_update(in_channel, in_sample, in_nudge);
        filtered_due.push_back(due_now);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          next_beat = beats_to_send.pop_front();
          in_channel <= next_beat.ch;
          in_sample <= next_beat.sample;
          in_nudge <= next_beat.nudge;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each accepted result and stalls in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (filtered_due.size() == 0) begin
          report_mismatch("result with nothing due, filtered", out_filtered, 0);
        end else begin
          seen_due = filtered_due.pop_front();
          if (out_channel_out != seen_due.ch)
            report_mismatch("channel_out", out_channel_out, seen_due.ch);
          if (out_filtered != seen_due.value)
            report_mismatch("filtered", out_filtered, seen_due.value);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus phases, each under its own noise setting
  initial begin
    q_noise = Q_RESET;
    r_noise = R_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      est_mem[i] = EST_RESET;
      var_mem[i] = VAR_RESET;
    end

    // reset defaults: field extremes, bit patterns, nudge driving the estimate to its ceiling
    queue_beat(0, 255, 0);
    queue_beat(0, 0, 0);
    queue_beat(0, 8'hAA, 8'h55);
    queue_beat(0, 8'h55, 8'hAA);
    queue_beat(3, 255, 255);
    queue_beat(3, 255, 255);
    queue_beat(3, 255, 255);
    queue_beat(3, 0, 0);
    queue_beat(3, 0, 0);
    queue_beat(1, 0, 255);
    queue_beat(1, 128, 1);
    queue_beat(2, 200, 0);
    queue_beat(2, 1, 0);
    for (int c = 0; c < CHANNELS; c++) queue_beat(c, 255, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    queue_random_beats(150);
    wait_quiet();

    // no noise at all: gain pinned just under one, then zero variance and zero denominator
    set_noise(CFG_PROCESS_NOISE, '0);
    set_noise(CFG_MEASUREMENT_NOISE, '0);
    for (int c = 0; c < CHANNELS; c++) begin
      queue_beat(c, 100, 0);
      queue_beat(c, 100, 0);
      queue_beat(c, 7, 0);
    end
    queue_random_beats(150);
    wait_quiet();

    // both noises at full scale, variance prediction saturates
    set_noise(CFG_PROCESS_NOISE, VAR_MAX);
    set_noise(CFG_MEASUREMENT_NOISE, VAR_MAX);
    queue_random_beats(180);
    wait_quiet();

    // full process noise, no measurement noise
    set_noise(CFG_MEASUREMENT_NOISE, '0);
    queue_random_beats(180);
    wait_quiet();

    // no process noise, full measurement noise
    set_noise(CFG_PROCESS_NOISE, '0);
    set_noise(CFG_MEASUREMENT_NOISE, VAR_MAX);
    queue_random_beats(180);
    wait_quiet();

    // random settings, some with idling on one side only
    for (int p = 0; p < 3; p++) begin
      gaps_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      set_noise(CFG_PROCESS_NOISE, CFG_W'($urandom));
      set_noise(CFG_MEASUREMENT_NOISE, CFG_W'($urandom));
      queue_random_beats(180);
      wait_quiet();
    end

    // small process noise, moderate measurement noise
    gaps_on = 1'b1;
    stall_on = 1'b1;
    set_noise(CFG_PROCESS_NOISE, CFG_W'($urandom_range(0, 4096)));
    set_noise(CFG_MEASUREMENT_NOISE, CFG_W'($urandom_range(0, 1 << 20)));
    queue_random_beats(180);
    wait_quiet();

    // back to the power-on setting at full rate
    gaps_on = 1'b0;
    stall_on = 1'b0;
    set_noise(CFG_PROCESS_NOISE, Q_RESET);
    set_noise(CFG_MEASUREMENT_NOISE, R_RESET);
    queue_random_beats(180);
    wait_quiet();

    // let any stray result show up
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS scalar_kalman_smoother");
    end else begin
      $display("FAIL scalar_kalman_smoother");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL scalar_kalman_smoother");
    $finish;
  end

endmodule

### sim.f
sv/kfs_pkg.sv
sv/kfs_state_mem.sv
sv/kfs_div.sv
sv/scalar_kalman_smoother.sv
tb/sv/scalar_kalman_smoother_test.sv
